/* hdl/sid_pkg.sv */
// shared types for the signed integer divider
package sid_pkg;

   // per-cycle command from the sequencer to the cell row
   typedef struct packed {
      logic load;   // clear partial remainder, take in divisor magnitude
      logic step;   // one shift and trial subtract
   } sid_ctrl_type;

endpackage

/* hdl/signed_integer_divider.sv */
// top level of the signed integer divider: sequencer, sign handling and result register
//
// usage
//   pulse or hold start with req_dividend and req_divisor; a transfer happens at a
//   rising edge where start is high and busy is low. busy stays high while the
//   operands are worked on.
//   the result appears on rsp_quotient and rsp_div_by_zero, marked by rsp_strobe for
//   exactly one cycle, once the DATA_WIDTH steps and the finishing state are done.
//   a new pair is accepted only when the block is idle again; the row of bit slices
//   retires one quotient bit per cycle in the run state, and the DATA_WIDTH steps, the
//   finishing state and the idle state that takes the next pair follow in turn.
//   the quotient is truncated toward zero. the most negative dividend over minus
//   one gives the largest positive value. a zero divisor gives quotient zero with
//   rsp_div_by_zero set.
//   a result must be taken in the cycle it is shown; there is no stall input.
//   reset (synchronous, active high) drops busy and rsp_strobe and abandons any
//   division in flight.
module signed_integer_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_dividend,
   input  logic signed [DATA_WIDTH-1:0] req_divisor,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_quotient,
   output logic                         rsp_div_by_zero
);
   import sid_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      FINISH
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DATA_WIDTH-1:0]  quo_ff;
   logic                   neg_ff;
   logic                   zero_ff;
   logic                   strobe_ff;
   logic [DATA_WIDTH-1:0]  quotient_ff;
   logic                   dbz_ff;

   logic                   accept;
   logic                   take;
   logic [DATA_WIDTH-1:0]  dvd_mag;
   logic [DATA_WIDTH-1:0]  dvs_mag;
   logic [DATA_WIDTH-1:0]  quo_fix;
   sid_ctrl_type           ctrl;

   assign accept = start & (state_ff == IDLE);

   // operand magnitudes as unsigned, the most negative value included
   assign dvd_mag = req_dividend[DATA_WIDTH-1] ? (~req_dividend + 1'b1) : req_dividend;
   assign dvs_mag = req_divisor[DATA_WIDTH-1] ? (~req_divisor + 1'b1) : req_divisor;

   assign ctrl.load = accept;
   assign ctrl.step = (state_ff == RUN);

   // bit-slice row holding the partial remainder
   sid_row #(
      .WIDTH (DATA_WIDTH)
   ) u_row (
      .clock     (clock),
      .ctrl      (ctrl),
      .dvs_mag   (dvs_mag),
      .serial_in (quo_ff[DATA_WIDTH-1]),
      .take      (take)
   );

   // sign, saturation and zero divisor on the final magnitude
   always_comb begin
      if (zero_ff) begin
         quo_fix = '0;
      end else if (neg_ff) begin
         quo_fix = ~quo_ff + 1'b1;
      end else if (quo_ff[DATA_WIDTH-1]) begin
         quo_fix = MAX_POS;
      end else begin
         quo_fix = quo_ff;
      end
   end

   // sequencer with dividend/quotient shift register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= RUN;
                  cnt_ff   <= '0;
                  quo_ff   <= dvd_mag;
                  neg_ff   <= req_dividend[DATA_WIDTH-1] ^ req_divisor[DATA_WIDTH-1];
                  zero_ff  <= (req_divisor == '0);
               end
            end
            RUN: begin
               quo_ff <= {quo_ff[DATA_WIDTH-2:0], take};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_STEP) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               state_ff    <= IDLE;
               strobe_ff   <= 1'b1;
               quotient_ff <= quo_fix;
               dbz_ff      <= zero_ff;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_quotient    = quotient_ff;
   assign rsp_div_by_zero = dbz_ff;

`ifndef SYNTHESIS
   // an accepted transfer makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transfer did not raise busy");

   // results never come on consecutive cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // a zero divisor result carries a zero quotient
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_div_by_zero) |-> (rsp_quotient == '0))
      else $error("zero divisor result with nonzero quotient");

   // the finishing step is always followed by a result
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH) |=> rsp_strobe)
      else $error("finishing step gave no result");

   // step counter only moves while dividing
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && !start) |=> $stable(cnt_ff))
      else $error("step counter moved while idle");
`endif

endmodule

/* hdl/sid_cell.sv */
// one bit slice of the partial remainder with its divisor bit and borrow stage
module sid_cell (
   input  logic                 clock,
   input  sid_pkg::sid_ctrl_type ctrl,
   input  logic                 dvs_load,
   input  logic                 shift_in,
   input  logic                 borrow_in,
   input  logic                 take,
   output logic                 rem_bit,
   output logic                 borrow_out
);
   import sid_pkg::*;

   logic rem_ff;
   logic rem_in;
   logic dvs_ff;
   logic dvs_in;
   logic diff;

   // full subtractor on the shifted remainder bit
   assign diff       = shift_in ^ dvs_ff ^ borrow_in;
   assign borrow_out = (~shift_in & dvs_ff) | (~(shift_in ^ dvs_ff) & borrow_in);

   // clear on load; keep the difference when the row subtracts, else shift
   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (ctrl.load) begin
         rem_in = 1'b0;
         dvs_in = dvs_load;
      end else if (ctrl.step) begin
         rem_in = take ? diff : shift_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rem_bit = rem_ff;

endmodule

/* hdl/sid_row.sv */
// row of bit slices forming the restoring division datapath
module sid_row #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  sid_pkg::sid_ctrl_type ctrl,
   input  logic [WIDTH-1:0]     dvs_mag,
   input  logic                 serial_in,
   output logic                 take
);
   import sid_pkg::*;

   logic [WIDTH-1:0] rem;
   logic [WIDTH-1:0] borrow;
   logic [WIDTH-1:0] shifted;
   logic [WIDTH-1:0] borrow_chain;

   // each slice takes its right neighbor's remainder bit, the lowest one the dividend bit
   assign shifted      = {rem[WIDTH-2:0], serial_in};
   assign borrow_chain = {borrow[WIDTH-2:0], 1'b0};

   // subtract when the shifted-out bit is set or the trial difference is not negative
   assign take = rem[WIDTH-1] | ~borrow[WIDTH-1];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      sid_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .dvs_load   (dvs_mag[i]),
         .shift_in   (shifted[i]),
         .borrow_in  (borrow_chain[i]),
         .take       (take),
         .rem_bit    (rem[i]),
         .borrow_out (borrow[i])
      );
   end

endmodule

/* dv/testbench.sv */
// self-checking testbench for the signed integer divider
`timescale 1ns / 1ps

module testbench;

   localparam int DW = 32;
   localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
   localparam int N_DIRECTED = 22;
   localparam int N_RANDOM_PER_PHASE = 495;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic signed [DW-1:0] quotient;
      logic                 div_by_zero;
   } div_result_type;

   typedef struct packed {
      logic signed [DW-1:0] dividend;
      logic signed [DW-1:0] divisor;
      logic                 typed_in;
      logic signed [DW-1:0] quotient;
      logic                 div_by_zero;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [DW-1:0] req_dividend = '0;
   logic signed [DW-1:0] req_divisor = '0;
   logic                 rsp_strobe;
   logic signed [DW-1:0] rsp_quotient;
   logic                 rsp_div_by_zero;

   div_result_type pending_quotients[$];
   int             mismatch_count = 0;
   int             stalled_cycles = 0;
   int             sender_idle_pct = 0;

   // directed rows: extremes, zero divisor, overflow, pass-through, sign combinations
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{32'sd0,      32'sd0,      1'b1, 32'sd0,       1'b1},
      '{MOST_POS,    32'sd0,      1'b1, 32'sd0,       1'b1},
      '{MOST_NEG,    32'sd0,      1'b1, 32'sd0,       1'b1},
      '{MOST_NEG,    -32'sd1,     1'b1, MOST_POS,     1'b0},
      '{MOST_NEG,    32'sd1,      1'b1, MOST_NEG,     1'b0},
      '{MOST_POS,    32'sd1,      1'b1, MOST_POS,     1'b0},
      '{-32'sd1,     32'sd1,      1'b1, -32'sd1,      1'b0},
      '{32'sd0,      MOST_NEG,    1'b1, 32'sd0,       1'b0},
      '{32'sd0,      -32'sd1,     1'b1, 32'sd0,       1'b0},
      '{MOST_POS,    -32'sd1,     1'b1, MOST_NEG + 1, 1'b0},
      '{MOST_NEG,    MOST_NEG,    1'b1, 32'sd1,       1'b0},
      '{MOST_POS,    MOST_POS,    1'b1, 32'sd1,       1'b0},
      '{-32'sd1,     -32'sd1,     1'b1, 32'sd1,       1'b0},
      '{MOST_NEG,    MOST_POS,    1'b0, 32'sd0,       1'b0},
      '{MOST_POS,    MOST_NEG,    1'b0, 32'sd0,       1'b0},
      '{32'sd7,      32'sd2,      1'b0, 32'sd0,       1'b0},
      '{-32'sd7,     32'sd2,      1'b0, 32'sd0,       1'b0},
      '{32'sd7,      -32'sd2,     1'b0, 32'sd0,       1'b0},
      '{-32'sd7,     -32'sd2,     1'b0, 32'sd0,       1'b0},
      '{32'sd1,      MOST_NEG,    1'b0, 32'sd0,       1'b0},
      '{32'h55555555, 32'hAAAAAAAA, 1'b0, 32'sd0,     1'b0},
      '{32'hAAAAAAAA, 32'sd3,     1'b0, 32'sd0,       1'b0}
   };

   signed_integer_divider #(
      .DATA_WIDTH(DW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_dividend(req_dividend),
      .req_divisor(req_divisor),
      .rsp_strobe(rsp_strobe),
      .rsp_quotient(rsp_quotient),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // truncating signed quotient with saturation and zero-divisor flag
   function automatic div_result_type predict_quotient(logic signed [DW-1:0] dividend,
                                                       logic signed [DW-1:0] divisor);
      logic [DW-1:0]  mag_dividend;
      logic [DW-1:0]  mag_divisor;
      logic [DW-1:0]  mag_quotient;
      div_result_type r;
      r.div_by_zero = (divisor == '0);
      r.quotient = '0;
      if (!r.div_by_zero) begin
         mag_dividend = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
         mag_divisor = divisor[DW-1] ? (~divisor + 1'b1) : divisor;
         mag_quotient = mag_dividend / mag_divisor;
         if (dividend[DW-1] != divisor[DW-1])
            r.quotient = ~mag_quotient + 1'b1;
         else if (mag_quotient[DW-1])
            r.quotient = MOST_POS;
         else
            r.quotient = mag_quotient;
      end
      return r;
   endfunction

   // operand mix: special values, small magnitudes of either sign, full random
   function automatic logic signed [DW-1:0] pick_operand();
      logic signed [DW-1:0] v;
      v = $urandom();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(5))
               0: v = '0;
               1: v = 32'sd1;
               2: v = -32'sd1;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               default: v = v[DW-1] ? MOST_NEG + 1 : MOST_POS - 1;
            endcase
         end
         1, 2, 3: v = v >>> $urandom_range(DW - 1);
         default: ;
      endcase
      return v;
   endfunction

   // optionally idle, present one pair, hold it until the block is idle again, then record the expected quotient
   task automatic transfer_pair(logic signed [DW-1:0] dividend, logic signed [DW-1:0] divisor,
                                div_result_type expected);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, DW + 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_dividend <= dividend;
      req_divisor <= divisor;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_quotients.push_back(expected);
   endtask

   // result checker
   always @(posedge clock) begin
      div_result_type expected;
      if (!reset && rsp_strobe) begin
         if (pending_quotients.size() == 0) begin
            $error("rsp_strobe with no quotient pending: quotient %0d, div_by_zero %0b",
                   rsp_quotient, rsp_div_by_zero);
            mismatch_count++;
         end else begin
            expected = pending_quotients.pop_front();
            if (rsp_quotient !== expected.quotient) begin
               $error("quotient: expected %0d, actual %0d", expected.quotient, rsp_quotient);
               mismatch_count++;
            end
            if (rsp_div_by_zero !== expected.div_by_zero) begin
               $error("div_by_zero: expected %0b, actual %0b", expected.div_by_zero,
                      rsp_div_by_zero);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("signed_integer_divider regression: fail");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic signed [DW-1:0] dividend;
      logic signed [DW-1:0] divisor;
      int                   multiple;
      int                   offset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows, sender idles lightly
      sender_idle_pct = 6;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed_in)
            transfer_pair(directed_rows[i].dividend, directed_rows[i].divisor,
                          div_result_type'{directed_rows[i].quotient,
                                           directed_rows[i].div_by_zero});
         else
            transfer_pair(directed_rows[i].dividend, directed_rows[i].divisor,
                          predict_quotient(directed_rows[i].dividend,
                                           directed_rows[i].divisor));
      end

      // random pairs: light idling, heavy idling, then back to back
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 74 : 0;
         for (int n = 0; n < N_RANDOM_PER_PHASE; n++) begin
            divisor = pick_operand();
            if ($urandom_range(3) == 0) begin
               // dividend near a multiple of the divisor
               multiple = $urandom_range(40);
               offset = $urandom_range(4);
               dividend = divisor * (multiple - 20) + (offset - 2);
            end else begin
               dividend = pick_operand();
            end
            transfer_pair(dividend, divisor, predict_quotient(dividend, divisor));
         end
      end
      start <= 1'b0;

      // drain and let any stray strobe show up
      while (pending_quotients.size() != 0) @(posedge clock);
      repeat (DW + 8) @(posedge clock);

      if (mismatch_count == 0)
         $display("signed_integer_divider regression: pass");
      else
         $display("signed_integer_divider regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
hdl/sid_pkg.sv
hdl/sid_cell.sv
hdl/sid_row.sv
hdl/signed_integer_divider.sv
dv/testbench.sv
